[rtl/acs_pkg.sv]
// acs_pkg: widths, register indexes, sensor kind codes and conversion constants
// shared by the averaging / conversion top level and its serial divider
// no dependencies
package acs_pkg;

   // field and datapath widths
   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int VALUE_W  = 31;
   localparam int SUM_W    = 32;
   localparam int CNT_W    = 11;
   localparam int NV_W     = 37;
   localparam int X_W      = 39;
   localparam int K_W      = 17;
   localparam int ACC_W    = 56;
   localparam int DVS_W    = 36;
   localparam int VAL_W    = 58;
   localparam int STEP_W   = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int MAX_SAMPLES_DEF = 32;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_KIND  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LSB_NV       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_FACTOR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_DIVIDER = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_OFFSET = 3'd6;

   // sensor kind codes
   localparam logic [3:0] KIND_MOIST_A   = 4'd0;
   localparam logic [3:0] KIND_TEMP_A    = 4'd1;
   localparam logic [3:0] KIND_BOARD_PCT = 4'd2;
   localparam logic [3:0] KIND_MOIST_B   = 4'd3;
   localparam logic [3:0] KIND_TEMP_B    = 4'd4;
   localparam logic [3:0] KIND_PIECEWISE = 4'd5;
   localparam logic [3:0] KIND_THERM     = 4'd6;
   localparam logic [3:0] KIND_LEVEL_PCT = 4'd7;
   localparam logic [3:0] KIND_USER      = 4'd8;
   localparam logic [3:0] KIND_VOLTS     = 4'd9;

   // register reset values
   localparam logic [15:0] PERIOD_RST = 16'd60;
   localparam logic [19:0] LSB_RST    = 20'd187500;

   // divider step counts
   localparam logic [STEP_W-1:0] STEPS_SHORT = STEP_W'(SUM_W);
   localparam logic [STEP_W-1:0] STEPS_LONG  = STEP_W'(ACC_W);

   // voltage breakpoints of the piecewise law, in nanovolts
   localparam logic signed [NV_W-1:0] NV_1V10 = 37'sd1100000000;
   localparam logic signed [NV_W-1:0] NV_1V30 = 37'sd1300000000;
   localparam logic signed [NV_W-1:0] NV_1V82 = 37'sd1820000000;
   localparam logic signed [NV_W-1:0] NV_2V20 = 37'sd2200000000;

   // offsets subtracted from the voltage before scaling
   localparam logic signed [X_W-1:0] XOFF_0V5  = 39'sd500000000;
   localparam logic signed [X_W-1:0] XOFF_1V2  = 39'sd1200000000;
   localparam logic signed [X_W-1:0] XOFF_0V1  = 39'sd100000000;
   localparam logic signed [X_W-1:0] XOFF_0V7  = 39'sd700000000;
   localparam logic signed [X_W-1:0] MEGA_X    = 39'sd1000000;

   // numerator constants for the sloped laws
   localparam logic signed [ACC_W-1:0] NUM_PW_C  = -56'sd4750000000000;
   localparam logic signed [ACC_W-1:0] NUM_PW_D  = -56'sd789000000000;
   localparam logic signed [ACC_W-1:0] NUM_PW_E  = -56'sd875000000000;
   localparam logic signed [ACC_W-1:0] NUM_THERM = -56'sd4000000000000;

   // denominators
   localparam logic [DVS_W-1:0] DEN_3M   = 36'd3000000;
   localparam logic [DVS_W-1:0] DEN_10K  = 36'd10000;
   localparam logic [DVS_W-1:0] DEN_33K  = 36'd33000;
   localparam logic [DVS_W-1:0] DEN_30K  = 36'd30000;
   localparam logic [DVS_W-1:0] DEN_100K = 36'd100000;
   localparam logic [DVS_W-1:0] DEN_40K  = 36'd40000;
   localparam logic [DVS_W-1:0] DEN_1E8  = 36'd100000000;
   localparam logic [DVS_W-1:0] DEN_1E7  = 36'd10000000;
   localparam logic [DVS_W-1:0] DEN_1M   = 36'd1000000;

   // output clamps
   localparam logic signed [VAL_W-1:0] PCT_HI    = 58'sd100000;
   localparam logic signed [VAL_W-1:0] LIMIT_HI  = 58'sd1000000000;
   localparam logic signed [VAL_W-1:0] LIMIT_LO  = -58'sd1000000000;
   localparam logic signed [VAL_W-1:0] TEN       = 58'sd10;

   typedef struct packed {
      logic start;
      logic short_op;
   } acs_div_ctl_type;

   typedef struct packed {
      logic done;
   } acs_div_stat_type;

endpackage

[rtl/acs_sdiv.sv]
// acs_sdiv: bit-serial restoring divider, one quotient bit per cycle
// short operations divide the low 32 dividend bits in 32 steps, long ones 56
// depends on acs_pkg
module acs_sdiv (
   input  logic                           clock,
   input  logic                           reset,
   input  acs_pkg::acs_div_ctl_type       ctl,
   input  logic [acs_pkg::ACC_W-1:0]      dividend,
   input  logic [acs_pkg::DVS_W-1:0]      divisor,
   output logic [acs_pkg::ACC_W-1:0]      quotient,
   output acs_pkg::acs_div_stat_type      stat
);
   import acs_pkg::*;

   logic [ACC_W-1:0]  work_ff, work_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, work_ff[ACC_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dvs_in  = divisor;
         if (ctl.short_op) begin
            work_in  = {dividend[SUM_W-1:0], {(ACC_W-SUM_W){1'b0}}};
            steps_in = STEPS_SHORT;
         end else begin
            work_in  = dividend;
            steps_in = STEPS_LONG;
         end
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         work_in  = {work_ff[ACC_W-2:0], fits};
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient  = work_ff;
   assign stat.done = done_ff;

endmodule

[rtl/adc_average_and_sensor_convert.sv]
// adc_average_and_sensor_convert: converter sample averaging and sensor law scaling
// an item that leaves the period open is taken and the input stays ready; a closing item
// holds off the input until its result is registered, after a 32-step serial average
// divide, a shift-add multiply of 1 to 16 steps and a 56-step serial rounding divide
// on the shared acs_sdiv, and longer while the previous result still waits
// synchronous active-high reset restores register defaults and clears sum, count,
// period start and result history; no clearing pass, ready right after reset
module adc_average_and_sensor_convert #(
   parameter int MAX_SAMPLES = acs_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input item channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [acs_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic        [acs_pkg::TIME_W-1:0]     req_now,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [acs_pkg::SAMPLE_W-1:0]   rsp_average_raw,
   output logic signed [acs_pkg::VALUE_W-1:0]    rsp_value_milli,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [acs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [acs_pkg::CSR_DATA_W-1:0] csr_data
);
   import acs_pkg::*;

   // one-hot sequencer
   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_AVG_GO   = 10'b0000000010,
      ST_AVG_WAIT = 10'b0000000100,
      ST_NV       = 10'b0000001000,
      ST_PREP     = 10'b0000010000,
      ST_MUL      = 10'b0000100000,
      ST_ABS      = 10'b0001000000,
      ST_RND      = 10'b0010000000,
      ST_DIV_WAIT = 10'b0100000000,
      ST_FIN      = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [3:0]         kind_ff, kind_in;
   logic [15:0]        period_ff, period_in;
   logic [19:0]        lsb_ff, lsb_in;
   logic signed [15:0] zoff_ff, zoff_in;
   logic signed [15:0] ufac_ff, ufac_in;
   logic signed [15:0] udiv_ff, udiv_in;
   logic signed [15:0] foff_ff, foff_in;

   // averaging state
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [TIME_W-1:0]       pb_ff, pb_in;
   logic                    has_ff, has_in;

   // conversion datapath
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic signed [NV_W-1:0]     nv_ff, nv_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    mx_ff, mx_in;
   logic [K_W-1:0]             mk_ff, mk_in;
   logic                       msub_ff, msub_in;
   logic [DVS_W-1:0]           dd_ff, dd_in;
   logic                       neg_ff, neg_in;
   logic signed [VAL_W-1:0]    val_ff, val_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic signed [VALUE_W-1:0]  rsp_val_ff, rsp_val_in;

   // accept-side helpers
   logic signed [SUM_W-1:0] sum_add;
   logic [TIME_W-1:0]       pb_new;
   logic [CNT_W-1:0]        cnt_inc;
   logic [CNT_W-1:0]        cnt_new;
   logic                    stay_open;
   logic [SUM_W-1:0]        sum_mag;

   // average result helpers
   logic [SUM_W-1:0]        q_avg;
   logic signed [SAMPLE_W-1:0] avg_clip;

   // law selection
   logic signed [X_W-1:0]   x_sel;
   logic [K_W-1:0]          k_sel;
   logic signed [ACC_W-1:0] c_sel;
   logic [DVS_W-1:0]        d_sel;
   logic                    sub_sel;

   // user law pieces
   logic signed [15:0]      f_nz, d_nz;
   logic signed [K_W-1:0]   f_ext, d_ext;
   logic [K_W-1:0]          f_mag, d_mag;
   logic signed [X_W-1:0]   w_user;

   // final stage
   logic signed [VAL_W-1:0] fin_sum;
   logic signed [VAL_W-1:0] fin_clip;

   // divider hookup
   acs_div_ctl_type         div_ctl;
   acs_div_stat_type        div_stat;
   logic [ACC_W-1:0]        div_dividend;
   logic [DVS_W-1:0]        div_divisor;
   logic [ACC_W-1:0]        div_quo;

   acs_sdiv u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // running sum and period bookkeeping for the incoming sample
   assign sum_add = sum_ff + SUM_W'(req_sample);
   assign pb_new  = (pb_ff == '0) ? (has_ff ? req_now : '0) : pb_ff;
   assign cnt_inc = cnt_ff + 1'b1;
   always_comb begin
      if (pb_new != '0) begin
         cnt_new = cnt_inc;
      end else if (pb_ff == '0 && !has_ff) begin
         cnt_new = CNT_W'(1);
      end else begin
         cnt_new = cnt_ff;
      end
   end
   // period end compared one bit wider so it never wraps
   assign stay_open = (pb_new != '0) && (cnt_inc < CNT_W'(MAX_SAMPLES)) &&
                      ({1'b0, req_now} < ({1'b0, pb_new} + {17'b0, period_ff}));

   assign sum_mag = SUM_W'(sum_ff[SUM_W-1] ? -sum_ff : sum_ff);

   // truncated average with 16-bit saturation
   assign q_avg = div_quo[SUM_W-1:0];
   always_comb begin
      if (neg_ff) begin
         avg_clip = (q_avg > SUM_W'(32768)) ? -16'sd32768 : SAMPLE_W'(-$signed(q_avg));
      end else begin
         avg_clip = (q_avg > SUM_W'(32767)) ? 16'sd32767 : SAMPLE_W'(q_avg);
      end
   end

   // user law: zero factor or divider means one, divider sign moves to the factor
   assign f_nz   = (ufac_ff == '0) ? 16'sd1 : ufac_ff;
   assign d_nz   = (udiv_ff == '0) ? 16'sd1 : udiv_ff;
   assign f_ext  = K_W'(f_nz);
   assign d_ext  = K_W'(d_nz);
   assign f_mag  = f_ext[K_W-1] ? K_W'(-f_ext) : K_W'(f_ext);
   assign d_mag  = d_ext[K_W-1] ? K_W'(-d_ext) : K_W'(d_ext);
   assign w_user = X_W'(nv_ff) - X_W'(zoff_ff) * MEGA_X;

   // value = round((k * x + c) / d) for the selected law
   always_comb begin
      x_sel   = X_W'(nv_ff);
      k_sel   = K_W'(1);
      c_sel   = '0;
      d_sel   = DEN_1M;
      sub_sel = 1'b0;
      case (kind_ff)
         KIND_MOIST_A: begin
            k_sel = K_W'(50);
            d_sel = DEN_3M;
         end
         KIND_TEMP_A: begin
            x_sel = X_W'(nv_ff) - XOFF_0V5;
            d_sel = DEN_10K;
         end
         KIND_BOARD_PCT: begin
            d_sel = DEN_33K;
         end
         KIND_MOIST_B, KIND_LEVEL_PCT: begin
            d_sel = DEN_30K;
         end
         KIND_TEMP_B: begin
            x_sel = X_W'(nv_ff) - XOFF_1V2;
            d_sel = DEN_30K;
         end
         KIND_PIECEWISE: begin
            if (nv_ff <= NV_1V10) begin
               x_sel = X_W'(nv_ff) - XOFF_0V1;
               d_sel = DEN_100K;
            end else if (nv_ff < NV_1V30) begin
               x_sel = X_W'(nv_ff) - XOFF_0V7;
               d_sel = DEN_40K;
            end else if (nv_ff < NV_1V82) begin
               k_sel = K_W'(4808);
               c_sel = NUM_PW_C;
               d_sel = DEN_1E8;
            end else if (nv_ff < NV_2V20) begin
               k_sel = K_W'(2632);
               c_sel = NUM_PW_D;
               d_sel = DEN_1E8;
            end else begin
               k_sel = K_W'(625);
               c_sel = NUM_PW_E;
               d_sel = DEN_1E7;
            end
         end
         KIND_THERM: begin
            k_sel = K_W'(4167);
            c_sel = NUM_THERM;
            d_sel = DEN_1E8;
         end
         KIND_USER: begin
            x_sel   = w_user;
            k_sel   = f_mag;
            sub_sel = f_ext[K_W-1] ^ d_ext[K_W-1];
            d_sel   = DVS_W'(d_mag) * DEN_1M;
         end
         default: begin
            // plain volts, also for undefined kinds
            d_sel = DEN_1M;
         end
      endcase
   end

   // user offset, percent clamps, then overall saturation
   assign fin_sum = val_ff + ((kind_ff == KIND_USER) ? VAL_W'(foff_ff) * TEN : '0);
   always_comb begin
      fin_clip = fin_sum;
      if (kind_ff inside {KIND_BOARD_PCT, KIND_LEVEL_PCT}) begin
         if (fin_sum < 0) begin
            fin_clip = '0;
         end else if (fin_sum > PCT_HI) begin
            fin_clip = PCT_HI;
         end
      end
      if (fin_clip > LIMIT_HI) begin
         fin_clip = LIMIT_HI;
      end else if (fin_clip < LIMIT_LO) begin
         fin_clip = LIMIT_LO;
      end
   end

   // divider operand selection
   always_comb begin
      div_ctl.start    = 1'b0;
      div_ctl.short_op = 1'b0;
      div_dividend     = $unsigned(acc_ff) + ACC_W'(dd_ff[DVS_W-1:1]);
      div_divisor      = dd_ff;
      if (state_ff == ST_AVG_GO) begin
         div_ctl.start    = 1'b1;
         div_ctl.short_op = 1'b1;
         div_dividend     = ACC_W'(sum_mag);
         div_divisor      = (cnt_ff == '0) ? DVS_W'(1) : DVS_W'(cnt_ff);
      end else if (state_ff == ST_RND) begin
         div_ctl.start = 1'b1;
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      pb_in        = pb_ff;
      has_in       = has_ff;
      avg_in       = avg_ff;
      nv_in        = nv_ff;
      acc_in       = acc_ff;
      mx_in        = mx_ff;
      mk_in        = mk_ff;
      msub_in      = msub_ff;
      dd_in        = dd_ff;
      neg_in       = neg_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_val_in   = rsp_val_ff;

      kind_in   = kind_ff;
      period_in = period_ff;
      lsb_in    = lsb_ff;
      zoff_in   = zoff_ff;
      ufac_in   = ufac_ff;
      udiv_in   = udiv_ff;
      foff_in   = foff_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SENSOR_KIND:  kind_in   = csr_data[3:0];
            CSR_PERIOD:       period_in = csr_data[15:0];
            CSR_LSB_NV:       lsb_in    = csr_data[19:0];
            CSR_ZERO_OFFSET:  zoff_in   = csr_data[15:0];
            CSR_USER_FACTOR:  ufac_in   = csr_data[15:0];
            CSR_USER_DIVIDER: udiv_in   = csr_data[15:0];
            CSR_FINAL_OFFSET: foff_in   = csr_data[15:0];
            default: begin
               // index beyond the register list is dropped
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sum_in = sum_add;
               cnt_in = cnt_new;
               if (stay_open) begin
                  pb_in = pb_new;
               end else begin
                  // period closes: next one starts unopened
                  pb_in    = '0;
                  has_in   = 1'b1;
                  state_in = ST_AVG_GO;
               end
            end
         end
         ST_AVG_GO: begin
            neg_in   = sum_ff[SUM_W-1];
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               avg_in   = avg_clip;
               // average seeds the next period as one sample
               sum_in   = SUM_W'(avg_clip);
               cnt_in   = CNT_W'(1);
               state_in = ST_NV;
            end
         end
         ST_NV: begin
            nv_in    = NV_W'(avg_ff) * NV_W'($signed({1'b0, lsb_ff}));
            state_in = ST_PREP;
         end
         ST_PREP: begin
            acc_in   = c_sel;
            mx_in    = ACC_W'(x_sel);
            mk_in    = k_sel;
            msub_in  = sub_sel;
            dd_in    = d_sel;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // one multiplier bit per cycle
            if (mk_ff == '0) begin
               state_in = ST_ABS;
            end else begin
               if (mk_ff[0]) begin
                  acc_in = msub_ff ? (acc_ff - mx_ff) : (acc_ff + mx_ff);
               end
               mx_in = mx_ff <<< 1;
               mk_in = mk_ff >> 1;
            end
         end
         ST_ABS: begin
            neg_in   = acc_ff[ACC_W-1];
            acc_in   = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
            state_in = ST_RND;
         end
         ST_RND: begin
            // divider starts on |num| + den/2, rounding halves away from zero
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               val_in   = neg_ff ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_val_in   = fin_clip[VALUE_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         pb_ff        <= '0;
         has_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KIND_MOIST_A;
         period_ff    <= PERIOD_RST;
         lsb_ff       <= LSB_RST;
         zoff_ff      <= '0;
         ufac_ff      <= '0;
         udiv_ff      <= '0;
         foff_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         pb_ff        <= pb_in;
         has_ff       <= has_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         period_ff    <= period_in;
         lsb_ff       <= lsb_in;
         zoff_ff      <= zoff_in;
         ufac_ff      <= ufac_in;
         udiv_ff      <= udiv_in;
         foff_ff      <= foff_in;
      end
      avg_ff     <= avg_in;
      nv_ff      <= nv_in;
      acc_ff     <= acc_in;
      mx_ff      <= mx_in;
      mk_ff      <= mk_in;
      msub_ff    <= msub_in;
      dd_ff      <= dd_in;
      neg_ff     <= neg_in;
      val_ff     <= val_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average_raw = rsp_avg_ff;
   assign rsp_value_milli = rsp_val_ff;

endmodule
